// ----- rtl/kvlex_pkg.sv -----
// Shared types and constants for the key/value text lexer.
// Used by kvlex_front, kvlex_queue, kvlex_back and keyvalues_text_lexer.
package kvlex_pkg;

  localparam int MAX_EV   = 4;
  localparam int EVCNT_W  = $clog2(MAX_EV + 1);
  localparam int EVIDX_W  = $clog2(MAX_EV);
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [2:0] EV_BYTE    = 3'd0;
  localparam logic [2:0] EV_DONE    = 3'd1;
  localparam logic [2:0] EV_OPEN    = 3'd2;
  localparam logic [2:0] EV_CLOSE   = 3'd3;
  localparam logic [2:0] EV_END     = 3'd4;
  localparam logic [2:0] EV_INVALID = 3'd5;

  typedef struct packed {
    logic [2:0] code;
    logic [7:0] val;
  } event_t;

  // All events caused by one input byte, in order; slots at and above cnt are unused.
  typedef struct packed {
    logic [EVCNT_W-1:0]       cnt;
    event_t [MAX_EV-1:0]      ev;
  } bundle_t;

endpackage

// ----- rtl/keyvalues_text_lexer.sv -----
// Key/value text lexer, top level: front end, bundle queue and output sequencer.
// A byte's events pass through the bundle queue and the output register before they appear.
// Throughput: one byte per cycle while out_ready is high and each byte yields at most one event;
// a byte's events leave one at a time, and a four-entry bundle queue absorbs bursts.
// Reset (rst_n low, synchronous): lexer mode returns between tokens, queue and output empty.
// Depends on kvlex_pkg, kvlex_front, kvlex_queue, kvlex_back.
module keyvalues_text_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_value_byte,
  output logic        out_run_last
);

  logic               push;
  logic               push_ready;
  logic               pop;
  logic               pop_valid;
  kvlex_pkg::bundle_t push_bundle;
  kvlex_pkg::bundle_t pop_bundle;

  kvlex_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_text_byte  (in_text_byte),
    .in_final_byte (in_final_byte),
    .q_ready       (push_ready),
    .q_push        (push),
    .q_bundle      (push_bundle)
  );

  kvlex_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_bundle (push_bundle),
    .push_ready  (push_ready),
    .pop         (pop),
    .pop_valid   (pop_valid),
    .pop_bundle  (pop_bundle)
  );

  kvlex_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (pop_valid),
    .q_bundle       (pop_bundle),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_res  (out_event_res),
    .out_value_byte (out_value_byte),
    .out_run_last   (out_run_last)
  );

endmodule

// ----- rtl/kvlex_front.sv -----
// Front end of the lexer: holds the lexer mode and turns each byte into a bundle of events.
// Depends on kvlex_pkg.
module kvlex_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_text_byte,
  input  logic                in_final_byte,
  input  logic                q_ready,
  output logic                q_push,
  output kvlex_pkg::bundle_t  q_bundle
);

  localparam logic [2:0] M_IDLE       = 3'd0;
  localparam logic [2:0] M_IDLE_SLASH = 3'd1;
  localparam logic [2:0] M_COMMENT    = 3'd2;
  localparam logic [2:0] M_WORD       = 3'd3;
  localparam logic [2:0] M_WORD_SLASH = 3'd4;
  localparam logic [2:0] M_QUOTE      = 3'd5;
  localparam logic [2:0] M_ESCAPE     = 3'd6;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;

  logic [2:0]         mode_r;
  logic [2:0]         mode_nxt;
  logic               word_step;
  logic               accept;
  kvlex_pkg::bundle_t bnd;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic kvlex_pkg::bundle_t push_ev(input kvlex_pkg::bundle_t b,
                                                 input logic [2:0] code,
                                                 input logic [7:0] val);
    kvlex_pkg::bundle_t r;
    r = b;
    if (b.cnt < kvlex_pkg::EVCNT_W'(kvlex_pkg::MAX_EV)) begin
      r.ev[b.cnt[kvlex_pkg::EVIDX_W-1:0]].code = code;
      r.ev[b.cnt[kvlex_pkg::EVIDX_W-1:0]].val  = (code == kvlex_pkg::EV_BYTE) ? val : 8'h00;
      r.cnt = b.cnt + kvlex_pkg::EVCNT_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    bnd       = '0;
    mode_nxt  = mode_r;
    word_step = 1'b0;

    unique case (mode_r)
      M_IDLE_SLASH: begin
        if (in_text_byte == CH_SLASH) begin
          mode_nxt = M_COMMENT;
        end else begin
          bnd       = push_ev(bnd, kvlex_pkg::EV_BYTE, CH_SLASH);
          word_step = 1'b1;
        end
      end
      M_COMMENT: begin
        if (in_text_byte == CH_LF) mode_nxt = M_IDLE;
      end
      M_WORD: begin
        word_step = 1'b1;
      end
      M_WORD_SLASH: begin
        if (in_text_byte == CH_SLASH) begin
          bnd      = push_ev(bnd, kvlex_pkg::EV_DONE, 8'h00);
          mode_nxt = M_COMMENT;
        end else begin
          bnd       = push_ev(bnd, kvlex_pkg::EV_BYTE, CH_SLASH);
          word_step = 1'b1;
        end
      end
      M_QUOTE: begin
        if (in_text_byte == CH_QUOTE) begin
          bnd      = push_ev(bnd, kvlex_pkg::EV_DONE, 8'h00);
          mode_nxt = M_IDLE;
        end else if (in_text_byte == CH_CR || in_text_byte == CH_LF ||
                     in_text_byte == CH_NUL) begin
          bnd      = push_ev(bnd, kvlex_pkg::EV_INVALID, 8'h00);
          mode_nxt = M_IDLE;
        end else if (in_text_byte == CH_BSLASH) begin
          mode_nxt = M_ESCAPE;
        end else begin
          bnd = push_ev(bnd, kvlex_pkg::EV_BYTE, in_text_byte);
        end
      end
      M_ESCAPE: begin
        if (in_text_byte == CH_BSLASH || in_text_byte == CH_QUOTE) begin
          bnd = push_ev(bnd, kvlex_pkg::EV_BYTE, in_text_byte);
        end else if (in_text_byte == CH_N) begin
          bnd = push_ev(bnd, kvlex_pkg::EV_BYTE, CH_LF);
        end else if (in_text_byte == CH_R) begin
          bnd = push_ev(bnd, kvlex_pkg::EV_BYTE, CH_CR);
        end else if (in_text_byte == CH_T) begin
          bnd = push_ev(bnd, kvlex_pkg::EV_BYTE, CH_TAB);
        end else begin
          bnd = push_ev(bnd, kvlex_pkg::EV_BYTE, CH_BSLASH);
          bnd = push_ev(bnd, kvlex_pkg::EV_BYTE, in_text_byte);
        end
        mode_nxt = M_QUOTE;
      end
      default: begin
        // Between tokens; the unused code falls in here as well.
        if (is_space(in_text_byte)) begin
          mode_nxt = M_IDLE;
        end else if (in_text_byte == CH_SLASH) begin
          mode_nxt = M_IDLE_SLASH;
        end else if (in_text_byte == CH_LBRACE) begin
          bnd      = push_ev(bnd, kvlex_pkg::EV_OPEN, 8'h00);
          mode_nxt = M_IDLE;
        end else if (in_text_byte == CH_RBRACE) begin
          bnd      = push_ev(bnd, kvlex_pkg::EV_CLOSE, 8'h00);
          mode_nxt = M_IDLE;
        end else if (in_text_byte == CH_QUOTE) begin
          mode_nxt = M_QUOTE;
        end else begin
          bnd      = push_ev(bnd, kvlex_pkg::EV_BYTE, in_text_byte);
          mode_nxt = M_WORD;
        end
      end
    endcase

    // Shared handling of a byte that continues a bare word.
    if (word_step) begin
      if (is_space(in_text_byte)) begin
        bnd      = push_ev(bnd, kvlex_pkg::EV_DONE, 8'h00);
        mode_nxt = M_IDLE;
      end else if (in_text_byte == CH_LBRACE || in_text_byte == CH_RBRACE) begin
        bnd      = push_ev(bnd, kvlex_pkg::EV_DONE, 8'h00);
        bnd      = push_ev(bnd, (in_text_byte == CH_LBRACE) ? kvlex_pkg::EV_OPEN
                                                            : kvlex_pkg::EV_CLOSE, 8'h00);
        mode_nxt = M_IDLE;
      end else if (in_text_byte == CH_SLASH) begin
        mode_nxt = M_WORD_SLASH;
      end else begin
        bnd      = push_ev(bnd, kvlex_pkg::EV_BYTE, in_text_byte);
        mode_nxt = M_WORD;
      end
    end

    // End of text closes whatever token is still open and adds the end event.
    if (in_final_byte) begin
      if (mode_nxt == M_IDLE_SLASH || mode_nxt == M_WORD_SLASH) begin
        bnd = push_ev(bnd, kvlex_pkg::EV_BYTE, CH_SLASH);
        bnd = push_ev(bnd, kvlex_pkg::EV_DONE, 8'h00);
      end else if (mode_nxt == M_WORD) begin
        bnd = push_ev(bnd, kvlex_pkg::EV_DONE, 8'h00);
      end else if (mode_nxt == M_QUOTE || mode_nxt == M_ESCAPE) begin
        bnd = push_ev(bnd, kvlex_pkg::EV_INVALID, 8'h00);
      end
      bnd      = push_ev(bnd, kvlex_pkg::EV_END, 8'h00);
      mode_nxt = M_IDLE;
    end
  end

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign q_push   = accept && (bnd.cnt != '0);
  assign q_bundle = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

  a_final_resets_mode: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_final_byte |=> mode_r == M_IDLE)
    else $error("mode not back between tokens after end of text");

  a_final_ends_with_end: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_final_byte |-> q_push &&
      bnd.ev[bnd.cnt[kvlex_pkg::EVIDX_W-1:0] - kvlex_pkg::EVIDX_W'(1)].code
        == kvlex_pkg::EV_END)
    else $error("end of text bundle does not close with an end event");

endmodule

// ----- rtl/kvlex_queue.sv -----
// Short queue of event bundles between the lexer front end and the output sequencer.
// Depends on kvlex_pkg.
module kvlex_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  kvlex_pkg::bundle_t  push_bundle,
  output logic                push_ready,
  input  logic                pop,
  output logic                pop_valid,
  output kvlex_pkg::bundle_t  pop_bundle
);

  kvlex_pkg::bundle_t               slot_r [kvlex_pkg::QDEPTH];
  logic [kvlex_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [kvlex_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [kvlex_pkg::QCNT_W-1:0]     count_r;
  logic                             do_push;
  logic                             do_pop;

  function automatic logic [kvlex_pkg::QPTR_W-1:0] bump(input logic [kvlex_pkg::QPTR_W-1:0] p);
    return (p == kvlex_pkg::QPTR_W'(kvlex_pkg::QDEPTH - 1)) ? '0 : p + kvlex_pkg::QPTR_W'(1);
  endfunction

  assign push_ready = (count_r != kvlex_pkg::QCNT_W'(kvlex_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_bundle = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_bundle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= bump(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (do_push && !do_pop)      count_r <= count_r + kvlex_pkg::QCNT_W'(1);
      else if (do_pop && !do_push) count_r <= count_r - kvlex_pkg::QCNT_W'(1);
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= kvlex_pkg::QCNT_W'(kvlex_pkg::QDEPTH))
    else $error("queue count out of range");

endmodule

// ----- rtl/kvlex_back.sv -----
// Output sequencer: takes one event bundle at a time and hands its events out in order.
// Depends on kvlex_pkg.
module kvlex_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  kvlex_pkg::bundle_t  q_bundle,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_event_res,
  output logic [7:0]          out_value_byte,
  output logic                out_run_last
);

  kvlex_pkg::bundle_t             cur_r;
  logic                           cur_valid_r;
  logic [kvlex_pkg::EVIDX_W-1:0]  idx_r;
  logic                           is_last;
  logic                           out_take;

  assign is_last  = (kvlex_pkg::EVCNT_W'(idx_r) + kvlex_pkg::EVCNT_W'(1)) == cur_r.cnt;
  assign out_take = cur_valid_r && out_ready;
  // The next bundle moves in as the last event of the current one leaves.
  assign q_pop    = q_valid && (!cur_valid_r || (out_take && is_last));

  assign out_valid      = cur_valid_r;
  assign out_event_res  = cur_r.ev[idx_r].code;
  assign out_value_byte = cur_r.ev[idx_r].val;
  assign out_run_last   = is_last;

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_bundle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (out_take) begin
      if (is_last) begin
        cur_valid_r <= 1'b0;
        idx_r       <= '0;
      end else begin
        idx_r <= idx_r + kvlex_pkg::EVIDX_W'(1);
      end
    end
  end

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> kvlex_pkg::EVCNT_W'(idx_r) < cur_r.cnt)
    else $error("event index past end of bundle");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && out_event_res == kvlex_pkg::EV_END |-> out_run_last)
    else $error("end event is not the last of its byte");

endmodule
